// ----- hdl/simple_risc_decode_execute_assert.svh -----
// Assertion macros for the decode/execute block
`ifndef SIMPLE_RISC_DECODE_EXECUTE_ASSERT_SVH
`define SIMPLE_RISC_DECODE_EXECUTE_ASSERT_SVH

// same-cycle implication
`define SRDE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srde assertion failed");

// next-cycle implication
`define SRDE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srde assertion failed");

`endif

// ----- hdl/srde_pkg.sv -----
// Package: opcodes, status codes, types and defaults for the decode/execute block
package srde_pkg;

    localparam int REG_COUNT_DEF   = 32;
    localparam int INSTR_BYTES_DEF = 4;
    localparam logic [31:0] RAM_BYTES_RST = 32'd65536;

    localparam logic [5:0] OP_ADD   = 6'h00;
    localparam logic [5:0] OP_ADDI  = 6'h01;
    localparam logic [5:0] OP_AND   = 6'h02;
    localparam logic [5:0] OP_ANDI  = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BEQI  = 6'h05;
    localparam logic [5:0] OP_BGE   = 6'h06;
    localparam logic [5:0] OP_BGEI  = 6'h07;
    localparam logic [5:0] OP_BGT   = 6'h08;
    localparam logic [5:0] OP_BGTI  = 6'h09;
    localparam logic [5:0] OP_BLE   = 6'h0A;
    localparam logic [5:0] OP_BLEI  = 6'h0B;
    localparam logic [5:0] OP_BLT   = 6'h0C;
    localparam logic [5:0] OP_BLTI  = 6'h0D;
    localparam logic [5:0] OP_BNE   = 6'h0E;
    localparam logic [5:0] OP_BNEI  = 6'h0F;
    localparam logic [5:0] OP_BRA   = 6'h10;
    localparam logic [5:0] OP_BRAI  = 6'h11;
    localparam logic [5:0] OP_CMP   = 6'h12;
    localparam logic [5:0] OP_IDIV  = 6'h13;
    localparam logic [5:0] OP_LD    = 6'h14;
    localparam logic [5:0] OP_LDI   = 6'h15;
    localparam logic [5:0] OP_MUL   = 6'h16;
    localparam logic [5:0] OP_MULI  = 6'h17;
    localparam logic [5:0] OP_OR    = 6'h19;
    localparam logic [5:0] OP_ORI   = 6'h1A;
    localparam logic [5:0] OP_RET   = 6'h1B;
    localparam logic [5:0] OP_SUB   = 6'h1C;
    localparam logic [5:0] OP_SUBI  = 6'h1D;
    localparam logic [5:0] OP_ST    = 6'h1E;
    localparam logic [5:0] OP_STI   = 6'h1F;
    localparam logic [5:0] OP_XOR   = 6'h20;
    localparam logic [5:0] OP_XORI  = 6'h21;
    localparam logic [5:0] OP_LAST  = OP_XORI;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_RET = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    typedef struct packed {
        logic [31:0] res;
        logic [31:0] npc;
        logic        wb;
        logic        br;
        logic        mem;
        logic        mw;
        logic        div;
        logic [1:0]  halt;
    } t_exec;

    typedef struct packed {
        logic [31:0] fetch_addr;
        logic        branch_taken;
        logic        mem_valid;
        logic        mem_write;
        logic        mem_external;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        wb_valid;
        logic [4:0]  wb_reg;
        logic [31:0] wb_value;
        logic [1:0]  status;
    } t_result;

endpackage

// ----- hdl/srde_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module srde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/srde_div.sv -----
// Iterative signed divider, one quotient bit per cycle, zero on a zero divisor
module srde_div
    import srde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        rem_sh = {r_rem[31:0], r_quo[31]};
        diff   = rem_sh - {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd32;
            n_rem  = '0;
            n_quo  = i_num[31] ? (32'd0 - i_num) : i_num;
            n_den  = i_den[31] ? (32'd0 - i_den) : i_den;
            n_neg  = i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!diff[32]) begin
                n_rem = diff;
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = (r_den == 32'd0) ? 32'd0 : (r_neg ? (32'd0 - r_quo) : r_quo);
endmodule

// ----- hdl/srde_alu.sv -----
// Decode and combinational execute: ALU, compare, multiply, branch target, memory address
module srde_alu
    import srde_pkg::*;
#(
    parameter int INSTR_BYTES = INSTR_BYTES_DEF
) (
    input  logic [5:0]  i_op,
    input  logic [15:0] i_imm,
    input  logic [31:0] i_va,
    input  logic [31:0] i_vb,
    input  logic [31:0] i_pc,
    output t_exec       o_ex
);
    logic [31:0] imm32;
    logic        cond;

    assign imm32 = {16'd0, i_imm};

    always_comb begin
        o_ex      = '0;
        o_ex.npc  = i_pc + 32'(INSTR_BYTES);
        cond      = 1'b0;
        if (i_op > OP_LAST) begin
            o_ex.npc  = i_pc;
            o_ex.halt = ST_BAD;
        end else if (i_op == OP_RET) begin
            o_ex.npc  = i_pc;
            o_ex.halt = ST_RET;
        end else begin
            unique case (i_op)
                OP_ADD:  begin o_ex.res = i_va + i_vb;  o_ex.wb = 1'b1; end
                OP_ADDI: begin o_ex.res = i_va + imm32; o_ex.wb = 1'b1; end
                OP_AND:  begin o_ex.res = i_va & i_vb;  o_ex.wb = 1'b1; end
                OP_ANDI: begin o_ex.res = i_va & imm32; o_ex.wb = 1'b1; end
                OP_BEQ, OP_BEQI: cond = (i_va == 32'd0);
                OP_BGE, OP_BGEI: cond = !i_va[31];
                OP_BGT, OP_BGTI: cond = !i_va[31] && (i_va != 32'd0);
                OP_BLE, OP_BLEI: cond = i_va[31] || (i_va == 32'd0);
                OP_BLT, OP_BLTI: cond = i_va[31];
                OP_BNE, OP_BNEI: cond = (i_va != 32'd0);
                OP_BRA:  begin o_ex.npc = i_vb;  o_ex.br = 1'b1; end
                OP_BRAI: begin o_ex.npc = imm32; o_ex.br = 1'b1; end
                OP_CMP: begin
                    o_ex.wb = 1'b1;
                    if ($signed(i_va) > $signed(i_vb)) begin
                        o_ex.res = 32'd1;
                    end else if ($signed(i_vb) > $signed(i_va)) begin
                        o_ex.res = '1;
                    end
                end
                OP_IDIV: begin o_ex.wb = 1'b1; o_ex.div = (i_va != 32'd0); end
                OP_LD:   begin o_ex.res = i_va + i_vb;  o_ex.mem = 1'b1; end
                OP_LDI:  begin o_ex.res = i_va + imm32; o_ex.mem = 1'b1; end
                OP_MUL:  begin o_ex.res = i_va * i_vb;  o_ex.wb = 1'b1; end
                OP_MULI: begin o_ex.res = i_va * imm32; o_ex.wb = 1'b1; end
                OP_OR:   begin o_ex.res = i_va | i_vb;  o_ex.wb = 1'b1; end
                OP_ORI:  begin o_ex.res = i_va | imm32; o_ex.wb = 1'b1; end
                OP_SUB:  begin o_ex.res = i_va - i_vb;  o_ex.wb = 1'b1; end
                OP_SUBI: begin o_ex.res = i_va - imm32; o_ex.wb = 1'b1; end
                OP_ST: begin
                    o_ex.res = i_va + i_vb; o_ex.mem = 1'b1; o_ex.mw = 1'b1;
                end
                OP_STI: begin
                    o_ex.res = i_va + imm32; o_ex.mem = 1'b1; o_ex.mw = 1'b1;
                end
                OP_XOR:  begin o_ex.res = i_va ^ i_vb;  o_ex.wb = 1'b1; end
                OP_XORI: begin o_ex.res = i_va ^ imm32; o_ex.wb = 1'b1; end
                default: ;
            endcase
            if (cond) begin
                o_ex.npc = i_pc + (i_op[0] ? imm32 : i_vb);
                o_ex.br  = 1'b1;
            end
        end
    end
endmodule

// ----- hdl/simple_risc_decode_execute.sv -----
// Top level: sequencer around the register-file RAMs, executes one transaction at a time
// One input transaction in flight. A load-data transaction, a transaction taken while
// halted or while a load is pending, has its result registered at the accepting edge.
// An instruction goes through a register RAM read, then execute and write-back; a store
// then also reads the store data register rd on the second RAM port, and idiv with a
// non-zero divisor waits for the 32-step shift-subtract divider. The register file is
// two mirrored RAMs, cleared at reset through per-entry valid bits, so no clearing
// pass runs.
// A new transaction is accepted in the cycle the previous result is taken.
module simple_risc_decode_execute
    import srde_pkg::*;
#(
    parameter int REG_COUNT   = REG_COUNT_DEF,
    parameter int INSTR_BYTES = INSTR_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [31:0]        i_instr_word,
    input  logic signed [31:0] i_load_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_fetch_addr,
    output logic               o_branch_taken,
    output logic               o_mem_valid,
    output logic               o_mem_write,
    output logic               o_mem_external,
    output logic [31:0]        o_mem_addr,
    output logic signed [31:0] o_mem_wdata,
    output logic               o_wb_valid,
    output logic [4:0]         o_wb_reg,
    output logic signed [31:0] o_wb_value,
    output logic [1:0]         o_status
);
    localparam int AW = $clog2(REG_COUNT);
    localparam logic [5:0] REG_LIM = 6'(REG_COUNT);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ST   = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    `include "simple_risc_decode_execute_assert.svh"

    logic [1:0]           r_state, n_state;
    logic [31:0]          r_pc;
    logic [1:0]           r_halt;
    logic                 r_ld_pend;
    logic [4:0]           r_ld_dest;
    logic [31:0]          r_ram_bytes;
    logic [31:0]          r_instr;
    logic [31:0]          r_vb;
    logic                 r_a_live;
    logic                 r_b_live;
    logic [REG_COUNT-1:0] r_vld;
    logic                 r_ov;
    t_result              r_out;

    logic        acc, bypass, fin, ld_wr;
    logic [4:0]  in_ra, in_rb, ex_rd;
    logic        re_b, we;
    logic [4:0]  raddr_b, waddr;
    logic [31:0] wdata, qa, qb, va, vb_q, vb_use, fin_res;
    logic        fin_wb;
    logic        div_start, div_busy, div_done;
    logic [31:0] div_quot;
    t_exec       ex;
    t_result     fin_out, byp_out;

    function automatic logic in_range(input logic [4:0] idx);
        return {1'b0, idx} < REG_LIM;
    endfunction

    assign in_ra  = i_instr_word[15:11];
    assign in_rb  = i_instr_word[20:16];
    assign ex_rd  = r_instr[10:6];

    assign o_in_ready = (r_state == S_IDLE) && (!r_ov || i_out_ready);
    assign acc        = i_in_valid && o_in_ready;
    assign bypass     = (r_halt != ST_RUN) || i_req_type || r_ld_pend;
    assign ld_wr      = acc && (r_halt == ST_RUN) && i_req_type && r_ld_pend
                        && in_range(r_ld_dest);

    assign va     = r_a_live ? qa : 32'd0;
    assign vb_q   = r_b_live ? qb : 32'd0;
    assign vb_use = (r_state == S_ST) ? r_vb : vb_q;

    srde_alu #(.INSTR_BYTES(INSTR_BYTES)) u_alu (
        .i_op  (r_instr[5:0]),
        .i_imm (r_instr[31:16]),
        .i_va  (va),
        .i_vb  (vb_use),
        .i_pc  (r_pc),
        .o_ex  (ex)
    );

    assign div_start = (r_state == S_EXEC) && ex.div;

    srde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (vb_use),
        .i_den   (va),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        fin     = 1'b0;
        re_b    = 1'b0;
        raddr_b = in_rb;
        unique case (r_state)
            S_IDLE: begin
                re_b = acc;
                if (acc && !bypass) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (ex.mem && ex.mw) begin
                    re_b    = 1'b1;
                    raddr_b = ex_rd;
                    n_state = S_ST;
                end else if (ex.div) begin
                    n_state = S_DIV;
                end else begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ST: begin
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    fin     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign fin_res = (r_state == S_DIV) ? div_quot : ex.res;
    assign fin_wb  = fin && ex.wb && in_range(ex_rd);

    always_comb begin
        fin_out              = '0;
        fin_out.fetch_addr   = ex.npc;
        fin_out.branch_taken = ex.br;
        fin_out.status       = ex.halt;
        if (ex.mem) begin
            fin_out.mem_valid    = 1'b1;
            fin_out.mem_write    = ex.mw;
            fin_out.mem_addr     = fin_res;
            fin_out.mem_external = ({1'b0, fin_res} + 33'd4) > {1'b0, r_ram_bytes};
            fin_out.mem_wdata    = ex.mw ? vb_q : 32'd0;
        end
        if (fin_wb) begin
            fin_out.wb_valid = 1'b1;
            fin_out.wb_reg   = ex_rd;
            fin_out.wb_value = fin_res;
        end

        byp_out            = '0;
        byp_out.fetch_addr = r_pc;
        byp_out.status     = r_halt;
        if (ld_wr) begin
            byp_out.wb_valid = 1'b1;
            byp_out.wb_reg   = r_ld_dest;
            byp_out.wb_value = $unsigned(i_load_data);
        end
    end

    assign we    = ld_wr || fin_wb;
    assign waddr = ld_wr ? r_ld_dest : ex_rd;
    assign wdata = ld_wr ? $unsigned(i_load_data) : fin_res;

    srde_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (acc),
        .i_raddr (in_ra[AW-1:0]),
        .o_rdata (qa)
    );

    srde_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr[AW-1:0]),
        .i_wdata (wdata),
        .i_re    (re_b),
        .i_raddr (raddr_b[AW-1:0]),
        .o_rdata (qb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_halt      <= ST_RUN;
            r_ld_pend   <= 1'b0;
            r_ld_dest   <= '0;
            r_ram_bytes <= RAM_BYTES_RST;
            r_vld       <= '0;
            r_ov        <= 1'b0;
            r_a_live    <= 1'b0;
            r_b_live    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ram_bytes <= i_cfg_wdata;
            end
            if (we) begin
                r_vld[waddr[AW-1:0]] <= 1'b1;
            end
            if (acc) begin
                r_a_live <= in_range(in_ra) && r_vld[in_ra[AW-1:0]];
            end
            if (re_b) begin
                r_b_live <= in_range(raddr_b) && r_vld[raddr_b[AW-1:0]];
            end
            if (acc && (r_halt == ST_RUN) && i_req_type) begin
                r_ld_pend <= 1'b0;
            end
            if (fin) begin
                r_pc   <= ex.npc;
                r_halt <= ex.halt;
                if (ex.mem && !ex.mw) begin
                    r_ld_pend <= 1'b1;
                    r_ld_dest <= ex_rd;
                end
            end
            if ((acc && bypass) || fin) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (acc && !bypass) begin
            r_instr <= i_instr_word;
        end
        if (r_state == S_EXEC) begin
            r_vb <= vb_q;
        end
        if (acc && bypass) begin
            r_out <= byp_out;
        end else if (fin) begin
            r_out <= fin_out;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_fetch_addr   = r_out.fetch_addr;
    assign o_branch_taken = r_out.branch_taken;
    assign o_mem_valid    = r_out.mem_valid;
    assign o_mem_write    = r_out.mem_write;
    assign o_mem_external = r_out.mem_external;
    assign o_mem_addr     = r_out.mem_addr;
    assign o_mem_wdata    = $signed(r_out.mem_wdata);
    assign o_wb_valid     = r_out.wb_valid;
    assign o_wb_reg       = r_out.wb_reg;
    assign o_wb_value     = $signed(r_out.wb_value);
    assign o_status       = r_out.status;

    `SRDE_ASSERT_IMP(a_no_result_overrun, i_clk, i_rst_n, fin, !r_ov || i_out_ready)
    `SRDE_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, r_halt != ST_RUN, r_halt == $past(r_halt))
    `SRDE_ASSERT_NXT(a_pc_frozen_halted, i_clk, i_rst_n, r_halt != ST_RUN, $stable(r_pc))
    `SRDE_ASSERT_IMP(a_div_only_in_div, i_clk, i_rst_n, div_busy, r_state == S_DIV)
endmodule
